### rtl/core/pck_pkg.sv
// Package for the penalization coefficient kernel: payload types, fixed-point
// constants, CORDIC arctangent table and saturation helper. No dependencies.
package pck_pkg;

  localparam int FracBits   = 16;
  localparam int WordBits   = 32;
  localparam int CordSteps  = 24;
  localparam int DivBits    = 48;
  localparam int AccBits    = 40;

  localparam logic signed [32:0] PiQ30     = 33'sd3373259426;
  localparam logic signed [32:0] Inv2PiQ30 = 33'sd170891319;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  typedef enum logic [1:0] {
    ACT_DAMP  = 2'd0,
    ACT_DIFF  = 2'd1,
    ACT_FORCE = 2'd2,
    ACT_MASK  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_ZONE_COUNT = 3'd0,
    REG_NEU_MASK   = 3'd1,
    REG_ALPHA0     = 3'd2,
    REG_ALPHA1     = 3'd3,
    REG_ETA0       = 3'd4,
    REG_ETA1       = 3'd5,
    REG_BC0        = 3'd6,
    REG_BC1        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] phi_lo_zone0;
    logic signed [31:0] phi_hi_zone0;
    logic signed [31:0] phi_lo_zone1;
    logic signed [31:0] phi_hi_zone1;
    logic signed [31:0] kappa;
    logic signed [31:0] field_value;
  } pck_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
  } pck_out_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    unique case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [AccBits-1:0] v);
    logic signed [AccBits-1:0] hi;
    logic signed [AccBits-1:0] lo;
    hi = AccBits'(32'sh7fff_ffff);
    lo = -hi - AccBits'(1);
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### rtl/core/pck_if.sv
// Valid/ready request channels of the penalization coefficient kernel.
// Depends on pck_pkg for the payload structs.
interface pck_in_if import pck_pkg::*; ();
  logic    valid;
  logic    ready;
  pck_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pck_out_if import pck_pkg::*; ();
  logic     valid;
  logic     ready;
  pck_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/penalization_coefficient_kernel.sv
// Brinkman penalization coefficient kernel, smoothed sine Heaviside, Q16.16.
// Depends on pck_pkg and the pck_in_if / pck_out_if channels.
//
// Usage: in_req carries one grid point request (action, level sets per zone,
// kappa, field value); out_req returns one result_value per request.
// Registers must be written via cfg_we_i/cfg_idx_i/cfg_data_i only while
// idle; the block leaves that to the user. One request is worked at a time;
// in_req.ready is high only when idle. Per active zone: a restoring division
// for r = phi/alpha, a 24-step CORDIC for the sine, and for damping/forcing
// in a zone without its neumann_mask bit a second division chi/eta, plus
// multiplies on the one shared multiplier. A level set outside the interface
// band skips the r division and the CORDIC for that zone.
// The result sits in an output register until out_req.ready; a stalled
// receiver holds the block in its final state, no request is taken then.
// Reset clears the sequencer and output valid and loads the register
// defaults: zone_count 0, neumann_mask 0, alpha and eta 1.0, bcval 0.
module penalization_coefficient_kernel import pck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pck_in_if.sink      in_req,
  pck_out_if.source   out_req
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ZONE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_ANGLE = 13'b0000000001000,
    S_MUL   = 13'b0000000010000,
    S_CINIT = 13'b0000000100000,
    S_CORD  = 13'b0000001000000,
    S_HEAV  = 13'b0000010000000,
    S_APPLY = 13'b0000100000000,
    S_QUOT  = 13'b0001000000000,
    S_ACC   = 13'b0010000000000,
    S_FINAL = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  localparam logic signed [17:0] One  = 18'sd65536;
  localparam logic signed [17:0] Half = 18'sd32768;

  state_e state_q, state_d, mul_next_q, mul_next_d;

  logic [1:0]  zone_count_q;
  logic [1:0]  neu_mask_q;
  logic [30:0] alpha_q [2];
  logic [30:0] eta_q [2];
  logic signed [31:0] bc_q [2];

  pck_in_t item_q, item_d;
  logic [1:0] zone_q, zone_d;
  logic [5:0] cnt_q, cnt_d;
  logic div_r_q, div_r_d;
  logic neg_q, neg_d;
  logic [DivBits-1:0] dvd_q, dvd_d;
  logic [30:0] rem_q, rem_d;
  logic [30:0] dvs_q, dvs_d;
  logic signed [17:0] r_q, r_d;
  logic signed [17:0] chi_q, chi_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [33:0] mul_a_q, mul_a_d;
  logic signed [32:0] mul_b_q, mul_b_d;
  logic signed [66:0] prod_q;
  logic signed [AccBits-1:0] acc_q, acc_d;
  logic out_valid_q, out_valid_d;
  logic signed [31:0] out_data_q, out_data_d;

  logic [1:0] active;
  logic       zsel;
  logic [30:0] alpha_e, eta_e;
  logic       neu;
  logic signed [32:0] sum_phi;
  logic signed [31:0] phi_lo, phi_hi, phi;
  logic signed [32:0] phi_x, alpha_x;
  logic [31:0] phi_abs;
  logic [31:0] div_t;
  logic signed [17:0] u;
  logic signed [66:0] prod_rnd;
  logic signed [33:0] sh_x, sh_y;
  logic signed [23:0] h;
  logic signed [AccBits-1:0] add_t;
  logic signed [31:0] q_sat;

  assign active  = (zone_count_q > 2'd2) ? 2'd2 : zone_count_q;
  assign zsel    = zone_q[0];
  assign alpha_e = (alpha_q[zsel] == '0) ? 31'd1 : alpha_q[zsel];
  assign eta_e   = (eta_q[zsel] == '0) ? 31'd1 : eta_q[zsel];
  assign neu     = neu_mask_q[zsel];
  assign phi_lo  = zsel ? item_q.phi_lo_zone1 : item_q.phi_lo_zone0;
  assign phi_hi  = zsel ? item_q.phi_hi_zone1 : item_q.phi_hi_zone0;
  assign sum_phi = 33'(phi_lo) + 33'(phi_hi);
  assign phi     = (action_e'(item_q.action) == ACT_DIFF) ? sum_phi[32:1] : phi_lo;
  assign phi_x   = 33'(phi);
  assign alpha_x = {2'b00, alpha_e};
  assign phi_abs = phi[31] ? 32'(-phi_x) : 32'(phi);
  assign div_t   = {rem_q, dvd_q[DivBits-1]};
  assign prod_rnd = prod_q + ((prod_q < 0) ? 67'sd65535 : 67'sd0);
  assign sh_x    = cx_q >>> cnt_q[4:0];
  assign sh_y    = cy_q >>> cnt_q[4:0];
  assign q_sat   = sat_word(AccBits'($signed({1'b0, dvd_q[33:0]})));

  always_comb begin
    if (r_q > Half) begin
      u = One - r_q;
    end else if (r_q < -Half) begin
      u = -One - r_q;
    end else begin
      u = r_q;
    end
  end

  always_comb begin
    logic signed [23:0] t;
    t = 24'(Half) + 24'(r_q >>> 1) + 24'(prod_q >>> 44);
    if (t < 0) begin
      h = '0;
    end else if (t > 24'(One)) begin
      h = 24'(One);
    end else begin
      h = t;
    end
  end

  always_comb begin
    logic signed [66:0] ps;
    ps = prod_q >>> FracBits;
    add_t = ps[AccBits-1:0];
    if (action_e'(item_q.action) == ACT_FORCE) begin
      if (ps > 67'sd2147483647) begin
        add_t = AccBits'(32'sh7fff_ffff);
      end else if (ps < -67'sd2147483648) begin
        add_t = AccBits'(32'sh8000_0000);
      end
    end
  end

  assign in_req.ready = (state_q == S_IDLE);
  assign out_req.valid = out_valid_q;
  assign out_req.data.result_value = out_data_q;

  always_comb begin
    state_d     = state_q;
    mul_next_d  = mul_next_q;
    item_d      = item_q;
    zone_d      = zone_q;
    cnt_d       = cnt_q;
    div_r_d     = div_r_q;
    neg_d       = neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    r_d         = r_q;
    chi_d       = chi_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_req.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_req.valid) begin
          item_d = in_req.data;
          zone_d = '0;
          unique case (action_e'(in_req.data.action))
            ACT_DAMP, ACT_FORCE: acc_d = '0;
            ACT_DIFF:            acc_d = AccBits'(in_req.data.kappa);
            ACT_MASK:            acc_d = AccBits'(One);
          endcase
          state_d = S_ZONE;
        end
      end
      S_ZONE: begin
        if (zone_q >= active) begin
          state_d = S_FINAL;
        end else if (phi_x < -alpha_x) begin
          chi_d   = 18'sd65536;
          state_d = S_APPLY;
        end else if (phi_x > alpha_x) begin
          chi_d   = '0;
          state_d = S_APPLY;
        end else begin
          neg_d   = phi[31];
          dvd_d   = DivBits'({phi_abs, 16'h0000});
          rem_d   = '0;
          dvs_d   = alpha_e;
          cnt_d   = '0;
          div_r_d = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_t >= {1'b0, dvs_q}) begin
          rem_d = 31'(div_t - {1'b0, dvs_q});
          dvd_d = {dvd_q[DivBits-2:0], 1'b1};
        end else begin
          rem_d = div_t[30:0];
          dvd_d = {dvd_q[DivBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivBits - 1)) begin
          state_d = div_r_q ? S_ANGLE : S_QUOT;
        end
      end
      S_ANGLE: begin
        r_d = neg_q ? -$signed({1'b0, dvd_q[16:0]}) : $signed({1'b0, dvd_q[16:0]});
        mul_a_d    = '0;
        mul_b_d    = PiQ30;
        mul_next_d = S_CINIT;
        if (r_d == r_q && cnt_q == '0) begin
          mul_a_d = 34'(u);
          state_d = S_MUL;
        end else begin
          cnt_d = '0;
        end
      end
      S_MUL: begin
        state_d = mul_next_q;
      end
      S_CINIT: begin
        cz_d    = 34'(prod_rnd >>> FracBits);
        cx_d    = GainQ30;
        cy_d    = '0;
        cnt_d   = '0;
        state_d = S_CORD;
      end
      S_CORD: begin
        if (cz_q >= 0) begin
          cx_d = cx_q - sh_y;
          cy_d = cy_q + sh_x;
          cz_d = cz_q - atan_q30(cnt_q[4:0]);
        end else begin
          cx_d = cx_q + sh_y;
          cy_d = cy_q - sh_x;
          cz_d = cz_q + atan_q30(cnt_q[4:0]);
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(CordSteps - 1)) begin
          mul_a_d    = cy_d;
          mul_b_d    = Inv2PiQ30;
          mul_next_d = S_HEAV;
          state_d    = S_MUL;
        end
      end
      S_HEAV: begin
        chi_d   = 18'(24'(One) - h);
        state_d = S_APPLY;
      end
      S_APPLY: begin
        zone_d  = zone_q + 2'd1;
        state_d = S_ZONE;
        unique case (action_e'(item_q.action))
          ACT_DAMP, ACT_FORCE: begin
            if (!neu) begin
              dvd_d   = DivBits'({chi_q, 16'h0000});
              rem_d   = '0;
              dvs_d   = eta_e;
              cnt_d   = '0;
              div_r_d = 1'b0;
              zone_d  = zone_q;
              state_d = S_DIV;
            end
          end
          ACT_DIFF: begin
            if (neu) begin
              mul_a_d    = 34'($signed({2'b00, eta_e}) - 33'(item_q.kappa));
              mul_b_d    = 33'(chi_q);
              mul_next_d = S_ACC;
              zone_d     = zone_q;
              state_d    = S_MUL;
            end
          end
          ACT_MASK: begin
            if (neu) begin
              acc_d = acc_q - AccBits'(chi_q);
            end
          end
        endcase
      end
      S_QUOT: begin
        if (action_e'(item_q.action) == ACT_FORCE) begin
          mul_a_d    = 34'(q_sat);
          mul_b_d    = 33'(bc_q[zsel]);
          mul_next_d = S_ACC;
          state_d    = S_MUL;
        end else begin
          acc_d   = acc_q + AccBits'($signed({1'b0, dvd_q[33:0]}));
          zone_d  = zone_q + 2'd1;
          state_d = S_ZONE;
        end
      end
      S_ACC: begin
        if (action_e'(item_q.action) == ACT_MASK) begin
          acc_d   = add_t;
          state_d = S_OUT;
        end else begin
          acc_d   = acc_q + add_t;
          zone_d  = zone_q + 2'd1;
          state_d = S_ZONE;
        end
      end
      S_FINAL: begin
        if (action_e'(item_q.action) == ACT_MASK) begin
          mul_a_d    = acc_q[33:0];
          mul_b_d    = 33'(item_q.field_value);
          mul_next_d = S_ACC;
          state_d    = S_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_req.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_word(acc_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mul_next_q   <= S_IDLE;
      out_valid_q  <= 1'b0;
      zone_count_q <= '0;
      neu_mask_q   <= '0;
      alpha_q[0]   <= 31'd65536;
      alpha_q[1]   <= 31'd65536;
      eta_q[0]     <= 31'd65536;
      eta_q[1]     <= 31'd65536;
      bc_q[0]      <= '0;
      bc_q[1]      <= '0;
    end else begin
      state_q     <= state_d;
      mul_next_q  <= mul_next_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_ZONE_COUNT: zone_count_q <= cfg_data_i[1:0];
          REG_NEU_MASK:   neu_mask_q   <= cfg_data_i[1:0];
          REG_ALPHA0:     alpha_q[0]   <= cfg_data_i[30:0];
          REG_ALPHA1:     alpha_q[1]   <= cfg_data_i[30:0];
          REG_ETA0:       eta_q[0]     <= cfg_data_i[30:0];
          REG_ETA1:       eta_q[1]     <= cfg_data_i[30:0];
          REG_BC0:        bc_q[0]      <= cfg_data_i;
          REG_BC1:        bc_q[1]      <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    zone_q     <= zone_d;
    cnt_q      <= cnt_d;
    div_r_q    <= div_r_d;
    neg_q      <= neg_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    r_q        <= r_d;
    chi_q      <= chi_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    prod_q     <= 67'(mul_a_q) * 67'(mul_b_q);
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

endmodule
